/* rtl/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PSFW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psfw assertion failed");

// Check that a condition never holds outside reset.
`define PSFW_NEVER(lbl, cond) \
  `PSFW_ASSERT(lbl, !(cond))

`endif

/* rtl/psfw_pkg.sv */
package psfw_pkg;

  localparam int unsigned MaxVerticesDef = 256;
  localparam int unsigned MaxEdgesDef    = 1024;
  localparam int unsigned CountW         = 9;
  localparam int unsigned WeightW        = 16;
  localparam int unsigned TotalW         = 24;

  // Key: infinite flag above a signed weight.
  typedef struct packed {
    logic                inf;
    logic [WeightW-1:0]  w;
  } key_t;

  localparam key_t KeyInf  = '{inf: 1'b1, w: '0};
  localparam key_t KeyZero = '{inf: 1'b0, w: '0};

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_LINK,
    OP_INIT,
    OP_X0,
    OP_X1,
    OP_SD0,
    OP_SD1,
    OP_EH,
    OP_E0,
    OP_E1,
    OP_E2,
    OP_E3,
    OP_U0,
    OP_U1,
    OP_NX,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic need_link;
    logic init_last;
    logic heap_empty;
    logic sd_stop;
    logic list_valid;
    logic dest_ok;
    logic pos_ok;
    logic key_less;
    logic at_root;
    logic up_less;
    logic has_link;
    logic out_busy;
  } sts_t;

  function automatic logic key_lt(key_t a, key_t b);
    return !a.inf && (b.inf || ($signed(a.w) < $signed(b.w)));
  endfunction

endpackage

/* rtl/psfw_ctrl.sv */
module psfw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  input  psfw_pkg::sts_t sts_i,
  output psfw_pkg::cmd_t cmd_o
);
  import psfw_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LINK = 5'd1;
  localparam logic [4:0] S_INIT = 5'd2;
  localparam logic [4:0] S_X0   = 5'd3;
  localparam logic [4:0] S_X1   = 5'd4;
  localparam logic [4:0] S_SD0  = 5'd5;
  localparam logic [4:0] S_SD1  = 5'd6;
  localparam logic [4:0] S_EH   = 5'd7;
  localparam logic [4:0] S_E0   = 5'd8;
  localparam logic [4:0] S_E1   = 5'd9;
  localparam logic [4:0] S_E2   = 5'd10;
  localparam logic [4:0] S_E3   = 5'd11;
  localparam logic [4:0] S_U0   = 5'd12;
  localparam logic [4:0] S_U1   = 5'd13;
  localparam logic [4:0] S_NX   = 5'd14;
  localparam logic [4:0] S_DONE = 5'd15;

  logic [4:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          last_d   = in_last_i;
          if (sts_i.need_link) state_d = S_LINK;
          else if (in_last_i) state_d = S_INIT;
        end
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        state_d  = last_q ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.init_last) state_d = S_X0;
      end
      S_X0: begin
        if (sts_i.heap_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_X0;
          state_d  = S_X1;
        end
      end
      S_X1: begin
        cmd_o.op = OP_X1;
        state_d  = S_SD0;
      end
      S_SD0: begin
        cmd_o.op = OP_SD0;
        state_d  = S_SD1;
      end
      S_SD1: begin
        cmd_o.op = OP_SD1;
        state_d  = sts_i.sd_stop ? S_EH : S_SD0;
      end
      S_EH: begin
        cmd_o.op = OP_EH;
        state_d  = sts_i.list_valid ? S_E0 : S_X0;
      end
      S_E0: begin
        cmd_o.op = OP_E0;
        state_d  = S_E1;
      end
      S_E1: begin
        cmd_o.op = OP_E1;
        state_d  = sts_i.dest_ok ? S_E2 : S_NX;
      end
      S_E2: begin
        cmd_o.op = OP_E2;
        state_d  = sts_i.pos_ok ? S_E3 : S_NX;
      end
      S_E3: begin
        cmd_o.op = OP_E3;
        state_d  = sts_i.key_less ? S_U0 : S_NX;
      end
      S_U0: begin
        cmd_o.op = OP_U0;
        state_d  = sts_i.at_root ? S_NX : S_U1;
      end
      S_U1: begin
        cmd_o.op = OP_U1;
        state_d  = sts_i.up_less ? S_U0 : S_NX;
      end
      S_NX: begin
        cmd_o.op = OP_NX;
        state_d  = sts_i.has_link ? S_E0 : S_X0;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

/* rtl/psfw_datapath.sv */
module psfw_datapath #(
  parameter int unsigned MAX_VERTICES = psfw_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = psfw_pkg::MaxEdgesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psfw_pkg::cmd_t                cmd_i,
  output psfw_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic [psfw_pkg::CountW-1:0]   cfg_data_i,
  input  logic [7:0]                    edge_source_i,
  input  logic [7:0]                    edge_dest_i,
  input  logic [psfw_pkg::WeightW-1:0]  edge_weight_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psfw_pkg::TotalW-1:0]   total_weight_o,
  output logic                          edges_dropped_o
);
  import psfw_pkg::*;

  localparam int unsigned VW   = $clog2(MAX_VERTICES);
  localparam int unsigned HW   = VW + 1;
  localparam int unsigned CW   = VW + 2;
  localparam int unsigned EW   = $clog2(MAX_EDGES);
  localparam int unsigned NW   = EW + 1;
  localparam int unsigned KW   = $bits(key_t);
  localparam int unsigned IW   = VW + KW;
  localparam int unsigned NCAP = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;

  // Edge store word: dest, weight. Link word: has_link, next edge.
  logic [8+WeightW-1:0] edge_mem [MAX_EDGES];
  logic [EW:0]          link_mem [MAX_EDGES];
  logic [EW-1:0]        head_mem [MAX_VERTICES];
  logic [EW-1:0]        tail_mem [MAX_VERTICES];
  logic [IW-1:0]        heap_mem [MAX_VERTICES];
  logic [VW-1:0]        pos_mem  [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] list_valid_q;
  logic [NW-1:0]           cnt_q;
  logic                    ovf_q;
  logic [CountW-1:0]       vc_q;
  logic [CountW-1:0]       n_q;
  logic [VW-1:0]           idx_q;
  logic [HW-1:0]           size_q;
  logic [TotalW-1:0]       sum_q;
  logic [VW-1:0]           u_q;
  logic [IW-1:0]           cur_q;
  logic [VW-1:0]           i_q;
  logic [EW-1:0]           e_q;

  logic [8+WeightW-1:0] edge_rd_q;
  logic [EW:0]          link_rd_q;
  logic [EW-1:0]        head_rd_q;
  logic [EW-1:0]        tail_rd_q;
  logic [IW-1:0]        rda_q, rdb_q;
  logic [VW-1:0]        pos_rd_q;

  logic                 out_valid_q;
  logic [TotalW-1:0]    total_q;
  logic                 dropped_q;

  logic [VW-1:0]      src_v;
  logic               src_ok, room;
  logic [CountW-1:0]  n_d;
  logic [CW-1:0]      lc, rc, size_c;
  logic               lval, rval, sel_l, sel_r;
  key_t               ak, bk, ck, mk, wk;
  logic [VW-1:0]      av, cv, parent;
  logic [IW-1:0]      child;
  logic [VW-1:0]      child_i;
  logic [7:0]         e_dest;
  logic [WeightW-1:0] e_w;

  logic [VW-1:0] ha_addr, hb_addr, hw_addr, pw_addr, pw_data;
  logic [IW-1:0] hw_data;
  logic          h_we, p_we;

  assign src_v  = VW'(edge_source_i);
  assign src_ok = (32'(edge_source_i) < MAX_VERTICES);
  assign room   = (32'(cnt_q) < MAX_EDGES);
  assign n_d    = (vc_q > CountW'(NCAP)) ? CountW'(NCAP) : vc_q;

  assign ak     = key_t'(rda_q[KW-1:0]);
  assign av     = rda_q[IW-1:KW];
  assign bk     = key_t'(rdb_q[KW-1:0]);
  assign ck     = key_t'(cur_q[KW-1:0]);
  assign cv     = cur_q[IW-1:KW];
  assign e_dest = edge_rd_q[8+WeightW-1:WeightW];
  assign e_w    = edge_rd_q[WeightW-1:0];
  assign wk     = '{inf: 1'b0, w: e_w};

  assign lc     = CW'({i_q, 1'b1});
  assign rc     = lc + CW'(1);
  assign size_c = CW'(size_q);
  assign lval   = lc < size_c;
  assign rval   = rc < size_c;
  assign sel_l  = lval && key_lt(ak, ck);
  assign mk     = sel_l ? ak : ck;
  assign sel_r  = rval && key_lt(bk, mk);
  assign child   = sel_r ? rdb_q : rda_q;
  assign child_i = sel_r ? rc[VW-1:0] : lc[VW-1:0];
  assign parent  = (i_q - VW'(1)) >> 1;

  always_comb begin
    sts_o.need_link  = src_ok && room && list_valid_q[src_v];
    sts_o.init_last  = (32'(idx_q) + 32'd1) >= 32'(n_q);
    sts_o.heap_empty = (size_q == '0);
    sts_o.sd_stop    = !sel_l && !sel_r;
    sts_o.list_valid = list_valid_q[u_q];
    sts_o.dest_ok    = {1'b0, e_dest} < n_q;
    sts_o.pos_ok     = HW'(pos_rd_q) < size_q;
    sts_o.key_less   = key_lt(wk, ak);
    sts_o.at_root    = (i_q == '0);
    sts_o.up_less    = key_lt(ck, ak);
    sts_o.has_link   = link_rd_q[EW];
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Heap and position port control.
  always_comb begin
    ha_addr = '0;
    hb_addr = VW'(size_q - HW'(1));
    hw_addr = i_q;
    hw_data = cur_q;
    h_we    = 1'b0;
    pw_addr = cv;
    pw_data = i_q;
    p_we    = 1'b0;
    case (cmd_i.op)
      OP_INIT: begin
        hw_addr = idx_q;
        hw_data = {idx_q, (idx_q == '0) ? KeyZero : KeyInf};
        h_we    = 1'b1;
        pw_addr = idx_q;
        pw_data = idx_q;
        p_we    = 1'b1;
      end
      OP_X1: begin
        pw_addr = av;
        pw_data = VW'(size_q - HW'(1));
        p_we    = 1'b1;
      end
      OP_SD0: begin
        ha_addr = lc[VW-1:0];
        hb_addr = rc[VW-1:0];
      end
      OP_SD1: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (!sts_o.sd_stop) begin
          hw_data = child;
          pw_addr = child[IW-1:KW];
        end
      end
      OP_E2: ha_addr = pos_rd_q;
      OP_U0: begin
        ha_addr = parent;
        if (sts_o.at_root) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end
      end
      OP_U1: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (sts_o.up_less) begin
          hw_data = rda_q;
          pw_addr = av;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rda_q <= heap_mem[ha_addr];
    rdb_q <= heap_mem[hb_addr];
    if (h_we) heap_mem[hw_addr] <= hw_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_E1) pos_rd_q <= pos_mem[VW'(e_dest)];
    if (p_we) pos_mem[pw_addr] <= pw_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_E0) begin
      edge_rd_q <= edge_mem[e_q];
      link_rd_q <= link_mem[e_q];
    end
    if (cmd_i.op == OP_LOAD && src_ok && room) begin
      edge_mem[cnt_q[EW-1:0]] <= {edge_dest_i, edge_weight_i};
      link_mem[cnt_q[EW-1:0]] <= '0;
    end else if (cmd_i.op == OP_LINK) begin
      link_mem[tail_rd_q] <= {1'b1, e_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_X1) head_rd_q <= head_mem[av];
    if (cmd_i.op == OP_LOAD) tail_rd_q <= tail_mem[src_v];
    if (cmd_i.op == OP_LOAD && src_ok && room) begin
      tail_mem[src_v] <= cnt_q[EW-1:0];
      if (!list_valid_q[src_v]) head_mem[src_v] <= cnt_q[EW-1:0];
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        n_q   <= n_d;
        idx_q <= '0;
        sum_q <= '0;
        e_q   <= cnt_q[EW-1:0];
      end
      OP_INIT: idx_q <= idx_q + VW'(1);
      OP_X1: begin
        u_q   <= av;
        cur_q <= rdb_q;
        i_q   <= '0;
        if (!ak.inf) sum_q <= sum_q + TotalW'($signed(ak.w));
      end
      OP_SD1: if (!sts_o.sd_stop) i_q <= child_i;
      OP_EH:  e_q <= head_rd_q;
      OP_E3: begin
        if (sts_o.key_less) begin
          cur_q <= {VW'(e_dest), wk};
          i_q   <= pos_rd_q;
        end
      end
      OP_U1: if (sts_o.up_less) i_q <= parent;
      OP_NX: e_q <= link_rd_q[EW-1:0];
      OP_DONE: begin
        total_q   <= sum_q;
        dropped_q <= ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_valid_q <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      vc_q         <= CountW'(1);
      size_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) vc_q <= cfg_data_i;
      if (cmd_i.op == OP_DONE) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          if (src_ok) begin
            if (room) begin
              cnt_q               <= cnt_q + NW'(1);
              list_valid_q[src_v] <= 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        OP_INIT: size_q <= HW'(n_q);
        OP_X1:   size_q <= size_q - HW'(1);
        OP_DONE: begin
          list_valid_q <= '0;
          cnt_q        <= '0;
          ovf_q        <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_weight_o  = total_q;
  assign edges_dropped_o = dropped_q;

endmodule

/* rtl/prim_spanning_forest_weight.sv */
// Spanning-forest weight by Prim's algorithm over an indexed binary min-heap.
// Edges stream in one transfer each and are appended to the out-list of their
// source vertex; when the list already holds an edge, a LINK step writes the
// link into the previous tail. The transfer with tlast starts the walk, which
// runs from memory: INIT fills the heap one vertex at a time, then each vertex
// extraction (X0, X1) is followed by sift-down levels (SD0, SD1) ending in a
// final compare; EH then fetches the out-list head, and each walked edge runs
// E0 on through E3 as far as it qualifies, then NX; an edge that lowers a key
// climbs the heap (U0, U1 per level). DONE closes the walk. No new edge is
// taken during the walk; the result sits in an output register so loading of
// the next graph may start before it is taken, and the walk holds at its end
// while an earlier result still waits. vertex_count may be written only while
// the block is idle.
`include "assert_macros.svh"

module prim_spanning_forest_weight #(
  parameter int unsigned MAX_VERTICES = psfw_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = psfw_pkg::MaxEdgesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [psfw_pkg::CountW-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // edge_source [7:0], edge_dest [15:8], edge_weight [31:16]
  input  logic [31:0]                 s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // total_weight [23:0]
  output logic [23:0]                 m_axis_tdata_o,
  // edges_dropped [0]
  output logic                        m_axis_tuser_o
);
  import psfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  psfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psfw_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .edge_source_i   (s_axis_tdata_i[7:0]),
    .edge_dest_i     (s_axis_tdata_i[15:8]),
    .edge_weight_i   (s_axis_tdata_i[31:16]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .total_weight_o  (m_axis_tdata_o),
    .edges_dropped_o (m_axis_tuser_o)
  );

  `PSFW_ASSERT(a_load_on_transfer, (cmd.op == OP_LOAD) |-> (s_axis_tvalid_i && s_axis_tready_o))
  `PSFW_ASSERT(a_done_shows_result, (cmd.op == OP_DONE) |=> m_axis_tvalid_o)
  `PSFW_NEVER(a_extract_from_empty, (cmd.op == OP_X1) && sts.heap_empty)

endmodule
